// ----- design/spu_pkg.sv -----
// Shared types, microcode program and constant tables for the permutation unranking unit.
`timescale 1ns / 1ps

package spu_pkg;

   // Widths fixed by the item fields
   localparam int SEED_W  = 64;
   localparam int FIELD_W = 5;
   localparam int STEP_W  = 3;

   localparam logic [FIELD_W-1:0] NUM_ITEMS_RESET = 5'd8;
   localparam logic [SEED_W-1:0]  SCRAMBLE_KEY    = 64'h0000_0000_9e35_c9b9;

   // Datapath operation selected by a control word
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_REDUCE,
      OP_SELECT,
      OP_COUNT,
      OP_EMIT
   } op_type;

   // Jump condition of a control word
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_IDLE,
      COND_BITS_LEFT,
      COND_RANK_GE,
      COND_LAST_POS
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // Status flags from the datapath that steer jumps
   typedef struct packed {
      logic bits_left;
      logic rank_ge;
      logic last_pos;
   } status_type;

   // Program step addresses
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_REDUCE = 3'd1;
   localparam step_type STEP_SELECT = 3'd2;
   localparam step_type STEP_COUNT  = 3'd3;
   localparam step_type STEP_EMIT   = 3'd4;
   localparam step_type STEP_NEXT   = 3'd5;

   // Control store: a true condition jumps to target, otherwise fall through
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      case (step)
         STEP_IDLE:   w = '{op: OP_LOAD,   cond: COND_IDLE,      target: STEP_IDLE};
         STEP_REDUCE: w = '{op: OP_REDUCE, cond: COND_BITS_LEFT, target: STEP_REDUCE};
         STEP_SELECT: w = '{op: OP_SELECT, cond: COND_NEVER,     target: STEP_IDLE};
         STEP_COUNT:  w = '{op: OP_COUNT,  cond: COND_RANK_GE,   target: STEP_COUNT};
         STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_LAST_POS,  target: STEP_IDLE};
         STEP_NEXT:   w = '{op: OP_NOP,    cond: COND_ALWAYS,    target: STEP_SELECT};
         default:     w = '{op: OP_NOP,    cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // k! for k = 0..20
   function automatic logic [SEED_W-1:0] factorial(input logic [FIELD_W-1:0] k);
      logic [SEED_W-1:0] f;
      case (k)
         5'd0:    f = 64'd1;
         5'd1:    f = 64'd1;
         5'd2:    f = 64'd2;
         5'd3:    f = 64'd6;
         5'd4:    f = 64'd24;
         5'd5:    f = 64'd120;
         5'd6:    f = 64'd720;
         5'd7:    f = 64'd5040;
         5'd8:    f = 64'd40320;
         5'd9:    f = 64'd362880;
         5'd10:   f = 64'd3628800;
         5'd11:   f = 64'd39916800;
         5'd12:   f = 64'd479001600;
         5'd13:   f = 64'd6227020800;
         5'd14:   f = 64'd87178291200;
         5'd15:   f = 64'd1307674368000;
         5'd16:   f = 64'd20922789888000;
         5'd17:   f = 64'd355687428096000;
         5'd18:   f = 64'd6402373705728000;
         5'd19:   f = 64'd121645100408832000;
         5'd20:   f = 64'd2432902008176640000;
         default: f = 64'd1;
      endcase
      return f;
   endfunction

   // Seed scrambler: key xor, then three xor-shift-left steps
   function automatic logic [SEED_W-1:0] scramble(input logic [SEED_W-1:0] seed);
      logic [SEED_W-1:0] x;
      x = seed ^ SCRAMBLE_KEY;
      x = x ^ (x << 6);
      x = x ^ (x << 7);
      x = x ^ (x << 15);
      return x;
   endfunction

endpackage

// ----- design/seeded_permutation_unrank_unit.sv -----
// Top level of the seeded permutation unranking unit.
//
// Usage: write the element count n (1..MAX_ITEMS; 0 reads as 1, larger as
// MAX_ITEMS) through csr_wr_en / csr_wr_data while the unit is idle. Raise
// start with a 64-bit seed on req_seed; the item is taken at an edge where
// start is high and busy is low. The seed is scrambled, reduced modulo n!
// and the permutation of 1..n of that rank is returned as n results, one
// element each, in position order; rsp_last marks the final one.
// Each result is shown for one cycle with rsp_valid high and cannot be held
// off by the receiver.
// Sequence: the modulo reduction takes one remainder bit per step of the
// microcode sequencer. Each position then runs a select step, repeated
// factorial subtraction that counts its factoradic digit d, an emit step,
// and a loop-back step for every position but the last. The next item can
// be taken in the cycle the last result shows.
// Reset returns the sequencer to idle, drops any item at work and sets n to 8.
`timescale 1ns / 1ps

module seeded_permutation_unrank_unit #(
   parameter int MAX_ITEMS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [spu_pkg::SEED_W-1:0]  req_seed,
   output logic                        rsp_valid,
   output logic [spu_pkg::FIELD_W-1:0] rsp_position,
   output logic [spu_pkg::FIELD_W-1:0] rsp_value,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [spu_pkg::FIELD_W-1:0] csr_wr_data
);

   logic [spu_pkg::FIELD_W-1:0] num_items_ff;
   spu_pkg::op_type             op;
   spu_pkg::status_type         status;

   // Hold the element count register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_items_ff <= spu_pkg::NUM_ITEMS_RESET;
      end else if (csr_wr_en) begin
         num_items_ff <= csr_wr_data;
      end
   end

   spu_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   spu_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .num_items    (num_items_ff),
      .seed         (req_seed),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- design/spu_sequencer.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module spu_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  spu_pkg::status_type status,
   output spu_pkg::op_type     op,
   output logic                busy
);

   spu_pkg::step_type  step_ff;
   spu_pkg::step_type  step_in;
   spu_pkg::uword_type uword;
   logic               take;

   // Fetch the control word of the current step
   always_comb begin
      uword = spu_pkg::ucode(step_ff);
   end

   // Evaluate the jump condition
   always_comb begin
      case (uword.cond)
         spu_pkg::COND_NEVER:     take = 1'b0;
         spu_pkg::COND_ALWAYS:    take = 1'b1;
         spu_pkg::COND_IDLE:      take = !start;
         spu_pkg::COND_BITS_LEFT: take = status.bits_left;
         spu_pkg::COND_RANK_GE:   take = status.rank_ge;
         spu_pkg::COND_LAST_POS:  take = status.last_pos;
         default:                 take = 1'b1;
      endcase
      step_in = take ? uword.target : step_ff + 3'd1;
   end

   // Drop the load operation unless an item is taken
   always_comb begin
      if (uword.op == spu_pkg::OP_LOAD && !start) begin
         op = spu_pkg::OP_NOP;
      end else begin
         op = uword.op;
      end
   end

   assign busy = (step_ff != spu_pkg::STEP_IDLE);

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= spu_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- design/spu_datapath.sv -----
// Datapath: rank reduction, factoradic digit counting, free-value scan and result register.
`timescale 1ns / 1ps

module spu_datapath #(
   parameter int MAX_ITEMS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spu_pkg::op_type             op,
   input  logic [spu_pkg::FIELD_W-1:0] num_items,
   input  logic [spu_pkg::SEED_W-1:0]  seed,
   output spu_pkg::status_type         status,
   output logic                        rsp_valid,
   output logic [spu_pkg::FIELD_W-1:0] rsp_position,
   output logic [spu_pkg::FIELD_W-1:0] rsp_value,
   output logic                        rsp_last
);

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   logic [spu_pkg::SEED_W-1:0]  rank_ff, rank_in;
   logic [spu_pkg::SEED_W-1:0]  dividend_ff, dividend_in;
   logic [spu_pkg::SEED_W-1:0]  factor_ff, factor_in;
   logic [5:0]                  bits_ff, bits_in;
   logic [spu_pkg::FIELD_W-1:0] count_ff, count_in;
   logic [spu_pkg::FIELD_W-1:0] pos_ff, pos_in;
   logic [MAX_ITEMS-1:0]        mask_ff, mask_in;
   logic [IDX_W-1:0]            cand_ff, cand_in;
   logic                        valid_ff, valid_in;
   logic [spu_pkg::FIELD_W-1:0] position_ff, position_in;
   logic [spu_pkg::FIELD_W-1:0] value_ff, value_in;
   logic                        last_ff, last_in;

   logic [spu_pkg::FIELD_W-1:0] n_eff;
   logic [spu_pkg::SEED_W-1:0]  shifted;
   logic                        rank_ge;
   logic                        last_pos;
   logic [IDX_W-1:0]            first_free;
   logic [IDX_W-1:0]            next_free;

   // Clamp the element count into 1..MAX_ITEMS
   always_comb begin
      if (num_items == '0) begin
         n_eff = 5'd1;
      end else if (num_items > 5'(MAX_ITEMS)) begin
         n_eff = 5'(MAX_ITEMS);
      end else begin
         n_eff = num_items;
      end
   end

   // Lowest free value, and lowest free value above the candidate
   always_comb begin
      first_free = '0;
      next_free  = cand_ff;
      for (int j = MAX_ITEMS - 1; j >= 0; j--) begin
         if (!mask_ff[j]) begin
            first_free = IDX_W'(j);
            if (IDX_W'(j) > cand_ff) begin
               next_free = IDX_W'(j);
            end
         end
      end
   end

   // Shift one dividend bit into the partial remainder (it stays below 2^62)
   assign shifted  = {rank_ff[spu_pkg::SEED_W-2:0], dividend_ff[spu_pkg::SEED_W-1]};
   assign rank_ge  = (rank_ff >= factor_ff);
   assign last_pos = (pos_ff == count_ff - 5'd1);

   assign status = '{bits_left: (bits_ff != '0), rank_ge: rank_ge, last_pos: last_pos};

   // Next-state logic for the operation of this step
   always_comb begin
      rank_in     = rank_ff;
      dividend_in = dividend_ff;
      factor_in   = factor_ff;
      bits_in     = bits_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      mask_in     = mask_ff;
      cand_in     = cand_ff;
      valid_in    = 1'b0;
      position_in = position_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      case (op)
         spu_pkg::OP_LOAD: begin
            rank_in     = '0;
            dividend_in = spu_pkg::scramble(seed);
            factor_in   = spu_pkg::factorial(n_eff);
            bits_in     = 6'd63;
            count_in    = n_eff;
            pos_in      = '0;
            mask_in     = '0;
         end
         spu_pkg::OP_REDUCE: begin
            // restoring remainder, one bit a step
            if (shifted >= factor_ff) begin
               rank_in = shifted - factor_ff;
            end else begin
               rank_in = shifted;
            end
            dividend_in = dividend_ff << 1;
            bits_in     = bits_ff - 6'd1;
         end
         spu_pkg::OP_SELECT: begin
            factor_in = spu_pkg::factorial(count_ff - 5'd1 - pos_ff);
            cand_in   = first_free;
         end
         spu_pkg::OP_COUNT: begin
            // each subtraction moves the candidate to the next free value
            if (rank_ge) begin
               rank_in = rank_ff - factor_ff;
               cand_in = next_free;
            end
         end
         spu_pkg::OP_EMIT: begin
            mask_in[cand_ff] = 1'b1;
            valid_in         = 1'b1;
            position_in      = pos_ff;
            value_in         = 5'(cand_ff) + 5'd1;
            last_in          = last_pos;
            pos_in           = pos_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   // Hold datapath state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= '0;
         bits_ff  <= '0;
         count_ff <= spu_pkg::NUM_ITEMS_RESET;
         pos_ff   <= '0;
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         rank_ff  <= rank_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
      dividend_ff <= dividend_in;
      factor_ff   <= factor_in;
      cand_ff     <= cand_in;
      position_ff <= position_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_position = position_ff;
   assign rsp_value    = value_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- design/spu_checker.sv -----
// Port-level checker for the permutation unranking unit, bound to the top level.
`timescale 1ns / 1ps

module spu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [spu_pkg::FIELD_W-1:0] rsp_value,
   input logic                        rsp_last
);

   // An item that is not finished keeps the unit busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("busy low while an item still has results to give");

   // The reduction stands between acceptance and the first result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("result right after an item was taken");

   // Results of one item are spaced apart
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> !rsp_valid)
      else $error("results on consecutive cycles");

   // Values are one-based
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value != '0)
      else $error("zero value in a result");

   // The unit goes idle only with the final result of an item
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_last)
      else $error("unit went idle without the final result");

endmodule

bind seeded_permutation_unrank_unit spu_checker u_spu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_value (rsp_value),
   .rsp_last  (rsp_last)
);

// ----- verif/tb_seeded_permutation_unrank_unit.sv -----
// Self-checking testbench for the seeded permutation unranking unit.
`timescale 1ns / 1ps

module tb_seeded_permutation_unrank_unit;

   localparam int          MAX_ITEMS   = 20;
   localparam logic [63:0] MIX_KEY     = 64'h0000_0000_9e35_c9b9;
   localparam int          SEED_ITEMS  = 310;
   localparam int          DRAIN_WAIT  = 40;

   typedef enum logic {ENTRY_SEED, ENTRY_COUNT} entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic [63:0]    payload;
   } pending_entry_type;

   typedef struct {
      logic [spu_pkg::FIELD_W-1:0] position;
      logic [spu_pkg::FIELD_W-1:0] value;
      logic                        last;
   } perm_element_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [spu_pkg::SEED_W-1:0]  req_seed;
   logic                        rsp_valid;
   logic [spu_pkg::FIELD_W-1:0] rsp_position;
   logic [spu_pkg::FIELD_W-1:0] rsp_value;
   logic                        rsp_last;
   logic                        csr_wr_en;
   logic [spu_pkg::FIELD_W-1:0] csr_wr_data;

   pending_entry_type stimulus_queue[$];
   perm_element_type  expected_elements[$];

   logic [spu_pkg::FIELD_W-1:0] count_shadow;
   int  issued_total;
   int  accepted_total;
   int  mismatch_count;
   int  gap_left;
   bit  no_idle;

   seeded_permutation_unrank_unit #(.MAX_ITEMS(MAX_ITEMS)) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_seed     (req_seed),
      .rsp_valid    (rsp_valid),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Seed scrambler: key xor, then xor-shift-left by 6, 7 and 15
   function automatic logic [63:0] mix_seed(input logic [63:0] seed);
      logic [63:0] x;
      x = seed ^ MIX_KEY;
      x = x ^ (x << 6);
      x = x ^ (x << 7);
      x = x ^ (x << 15);
      return x;
   endfunction

   // Invert one x ^= x << s step
   function automatic logic [63:0] undo_shift_xor(input logic [63:0] y, input int s);
      logic [63:0] r;
      logic [63:0] t;
      r = y;
      t = y;
      for (int k = 0; k < 64; k++) begin
         t = t << s;
         r = r ^ t;
      end
      return r;
   endfunction

   // Seed whose scrambled value equals the given rank
   function automatic logic [63:0] seed_for_rank(input logic [63:0] rank);
      logic [63:0] y;
      y = undo_shift_xor(rank, 15);
      y = undo_shift_xor(y, 7);
      y = undo_shift_xor(y, 6);
      return y ^ MIX_KEY;
   endfunction

   function automatic logic [63:0] factorial_of(input int k);
      logic [63:0] f;
      f = 64'd1;
      for (int j = 2; j <= k; j++) f = f * 64'(j);
      return f;
   endfunction

   // Element count as the unit sees it: 0 reads as 1, above range as MAX_ITEMS
   function automatic int clamp_count(input logic [spu_pkg::FIELD_W-1:0] reg_value);
      int n;
      n = int'(reg_value);
      if (n < 1) n = 1;
      if (n > MAX_ITEMS) n = MAX_ITEMS;
      return n;
   endfunction

   // Unrank the scrambled seed and queue the expected permutation elements
   task automatic predict_permutation(input logic [spu_pkg::FIELD_W-1:0] reg_value,
                                      input logic [63:0] seed);
      int               n;
      int               seen;
      bit               found;
      logic [63:0]      rank;
      logic [63:0]      f;
      logic [63:0]      digit;
      logic [19:0]      taken;
      perm_element_type e;
      n = clamp_count(reg_value);
      rank = mix_seed(seed) % factorial_of(n);
      taken = '0;
      for (int i = 0; i < n; i++) begin
         f = factorial_of(n - 1 - i);
         digit = rank / f;
         rank = rank % f;
         seen = 0;
         found = 1'b0;
         e.value = '0;
         for (int v = 0; v < n; v++) begin
            if (!found && !taken[v]) begin
               if (64'(seen) == digit) begin
                  taken[v] = 1'b1;
                  e.value = 5'(v + 1);
                  found = 1'b1;
               end
               seen++;
            end
         end
         e.position = 5'(i);
         e.last = (i == n - 1);
         expected_elements = {expected_elements, e};
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_seed(input logic [63:0] seed);
      pending_entry_type p;
      p.kind = ENTRY_SEED;
      p.payload = seed;
      stimulus_queue = {stimulus_queue, p};
   endtask

   task automatic queue_count(input logic [spu_pkg::FIELD_W-1:0] count);
      pending_entry_type p;
      p.kind = ENTRY_COUNT;
      p.payload = 64'(count);
      stimulus_queue = {stimulus_queue, p};
   endtask

   // Drive items and register writes from the pending queue at the falling edge
   always @(negedge clock) begin : drive_items
      logic                        nxt_start;
      logic                        nxt_wr_en;
      logic [63:0]                 nxt_seed;
      logic [spu_pkg::FIELD_W-1:0] nxt_wr_data;
      nxt_start   = start;
      nxt_wr_en   = 1'b0;
      nxt_seed    = req_seed;
      nxt_wr_data = csr_wr_data;
      // hold start until the item is taken
      if (!reset && !(start && accepted_total < issued_total)) begin
         nxt_start = 1'b0;
         if (gap_left > 0) begin
            if (!busy) gap_left--;
         end else if (stimulus_queue.size() > 0) begin
            if (stimulus_queue[0].kind == ENTRY_SEED) begin
               nxt_start = 1'b1;
               nxt_seed  = stimulus_queue[0].payload;
               issued_total++;
               void'(stimulus_queue.pop_front());
               gap_left = no_idle ? 0 : $urandom_range(0, 4);
            end else if (expected_elements.size() == 0 && !busy) begin
               // register writes only once the unit has drained
               nxt_wr_en   = 1'b1;
               nxt_wr_data = stimulus_queue[0].payload[spu_pkg::FIELD_W-1:0];
               void'(stimulus_queue.pop_front());
               no_idle  = ($urandom_range(0, 3) == 0);
               gap_left = no_idle ? 0 : $urandom_range(0, 4);
            end
         end
      end
      start       <= nxt_start;
      req_seed    <= nxt_seed;
      csr_wr_en   <= nxt_wr_en;
      csr_wr_data <= nxt_wr_data;
   end

   // Sample handshakes at the rising edge: check results, predict new items
   always @(posedge clock) begin : watch_unit
      perm_element_type e;
      if (reset) begin
         count_shadow = spu_pkg::NUM_ITEMS_RESET;
      end else begin
         if (rsp_valid) begin
            if (expected_elements.size() == 0) begin
               report_mismatch($sformatf("unexpected element pos=%0d val=%0d last=%0b",
                                         rsp_position, rsp_value, rsp_last));
            end else begin
               e = expected_elements.pop_front();
               if (rsp_position !== e.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_position, e.position));
               if (rsp_value !== e.value)
                  report_mismatch($sformatf("value %0d at position %0d, expected %0d",
                                            rsp_value, e.position, e.value));
               if (rsp_last !== e.last)
                  report_mismatch($sformatf("last %0b at position %0d, expected %0b",
                                            rsp_last, e.position, e.last));
            end
         end
         if (start && !busy) begin
            predict_permutation(count_shadow, req_seed);
            accepted_total++;
         end
         if (csr_wr_en) count_shadow = csr_wr_data;
      end
   end

   // Stimulus, reset and end of run
   initial begin : run_test
      int          phase_n;
      int          seeds_queued;
      int          phase_len;
      logic [63:0] top;
      logic [spu_pkg::FIELD_W-1:0] cfg;
      reset          = 1'b1;
      start          = 1'b0;
      req_seed       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      count_shadow   = spu_pkg::NUM_ITEMS_RESET;
      issued_total   = 0;
      accepted_total = 0;
      mismatch_count = 0;
      gap_left       = 0;
      no_idle        = 1'b0;

      // directed: reset count of 8, both ends of the rank
      queue_seed(64'd0);
      queue_seed({64{1'b1}});
      queue_seed(seed_for_rank(64'd0));
      queue_seed(seed_for_rank(factorial_of(8) - 1));
      queue_seed(64'h8000_0000_0000_0000);
      // largest count: 20! fits, highest rank is the slowest item
      queue_count(5'd20);
      queue_seed(seed_for_rank(64'd0));
      queue_seed(seed_for_rank(factorial_of(20) - 1));
      queue_seed({64{1'b1}});
      queue_seed(seed_for_rank(factorial_of(20) / 2));
      // count below range reads as one element
      queue_count(5'd0);
      queue_seed(64'd0);
      queue_seed({64{1'b1}});
      // count above range clamps to the maximum
      queue_count(5'd31);
      queue_seed(seed_for_rank(factorial_of(20) - 1));
      queue_seed(64'd1);
      queue_count(5'd1);
      queue_seed(64'ha5a5_a5a5_5a5a_5a5a);
      queue_count(5'd21);
      queue_seed(64'h5555_5555_5555_5555);
      queue_count(5'd2);
      queue_seed(seed_for_rank(64'd0));
      queue_seed(seed_for_rank(64'd1));
      queue_count(5'd3);
      queue_seed(seed_for_rank(64'd5));
      queue_seed(seed_for_rank(64'd3));
      seeds_queued = 19;

      // random phases, each under its own count
      while (seeds_queued < SEED_ITEMS) begin
         case ($urandom_range(0, 7))
            0, 1:    cfg = 5'd20;
            2:       cfg = 5'($urandom_range(0, 31));
            default: cfg = 5'($urandom_range(1, 19));
         endcase
         queue_count(cfg);
         phase_n = clamp_count(cfg);
         top = factorial_of(phase_n);
         phase_len = $urandom_range(5, 25);
         for (int k = 0; k < phase_len; k++) begin
            case ($urandom_range(0, 9))
               7:       queue_seed(seed_for_rank(top - 1 - (64'($urandom_range(0, 15)) % top)));
               8:       queue_seed(seed_for_rank({$urandom, $urandom} % top));
               9:       queue_seed(($urandom_range(0, 1) ? 64'd1 : ~64'd0)
                                   << $urandom_range(0, 63));
               default: queue_seed({$urandom, $urandom});
            endcase
            seeds_queued++;
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every item to be taken and every element to arrive
      while (stimulus_queue.size() > 0 || accepted_total < issued_total
             || expected_elements.size() > 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (expected_elements.size() != 0)
         report_mismatch($sformatf("%0d elements never arrived", expected_elements.size()));
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Give up on a hung run
   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
design/spu_pkg.sv
design/spu_sequencer.sv
design/spu_datapath.sv
design/seeded_permutation_unrank_unit.sv
design/spu_checker.sv
verif/tb_seeded_permutation_unrank_unit.sv
